// ===== hdl/rihf_pkg.sv =====
`timescale 1ns / 1ps
package rihf_pkg;

  localparam int MAX_COLS   = 2048;
  localparam int MAX_ROWS   = 128;
  localparam int MAX_RADIUS = 3;

  localparam int PIX_W   = 32;
  localparam int COL_W   = 11;            // column position 0..MAX_COLS-1
  localparam int COLC_W  = 12;            // column count 1..MAX_COLS
  localparam int ROW_W   = 8;             // row position, may reach MAX_ROWS
  localparam int RAD_W   = 2;
  localparam int CNT_W   = 6;             // nonzero count in a window, up to 49
  localparam int SUM_W   = 38;            // 49 * (2^32 - 1) fits
  localparam int LROW_W  = 3;             // rows kept in the line store: 8
  localparam int ADDR_W  = LROW_W + COL_W;
  localparam int CFG_W   = 12;
  localparam int CFGA_W  = 2;
  localparam int WIN_MAX = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);

  localparam logic [RAD_W-1:0]  RADIUS_RST = 2'd1;
  localparam logic [CNT_W-1:0]  MINV_RST   = 6'd1;
  localparam logic [COLC_W-1:0] COLS_RST   = 12'd1024;
  localparam logic [ROW_W-1:0]  ROWS_RST   = 8'd128;

  typedef enum logic [CFGA_W-1:0] {
    CFG_RADIUS = 2'd0,
    CFG_MINV   = 2'd1,
    CFG_COLS   = 2'd2,
    CFG_ROWS   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [PIX_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== hdl/rihf_line_mem.sv =====
`timescale 1ns / 1ps
module rihf_line_mem import rihf_pkg::*; (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [PIX_W-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [PIX_W-1:0]  rd_data
);

  logic [PIX_W-1:0] mem [1 << ADDR_W];
  logic [PIX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/rihf_div.sv =====
`timescale 1ns / 1ps
module rihf_div import rihf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int STEP_W = $clog2(SUM_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [SUM_W-1:0]  num_r, num_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  den_r, den_nxt;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              ge;

  // restoring division, one quotient bit per cycle; quotient shifts into num_r
  assign trial = {rem_r, num_r[SUM_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      num_nxt  = req.dividend;
      rem_nxt  = '0;
      den_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      num_nxt = {num_r[SUM_W-2:0], ge};
      if (step_r == STEP_W'(SUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = num_r[PIX_W-1:0];

endmodule

// ===== hdl/range_image_hole_fill_core.sv =====
`timescale 1ns / 1ps
// Range image hole filler. Pixels of a frame arrive in raster order, then flush
// items (tuser = 1) drain the pixels still waiting for their window. A zero pixel
// becomes the floor mean of the nonzero original pixels in its (2R+1)x(2R+1)
// window, clipped at the frame edges, when at least min_valid of them are
// nonzero. One item is worked on at a time, all state reads going through the
// single-port-read line store (8 rows of 2048 pixels, registered read). An item
// that emits nothing passes the idle and check states; a nonzero pixel then goes
// through the centre read to emit; a hole scans the W pixels of its clipped window
// (at most 49), then waits for the bit-serial divider when filled, before emit. A
// finished result waits in the output register while the next item is taken. No
// clearing pass is needed after reset. Any configuration write abandons the frame.
module range_image_hole_fill_core import rihf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [PIX_W-1:0]  in_tdata,   // [31:0] range_value
  input  logic              in_tuser,   // [0] flush
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [PIX_W-1:0]  out_tdata,  // [31:0] range_out
  output logic              out_tuser,  // [0] was_filled
  output logic              out_tlast,
  input  logic              cfg_we,
  input  logic [CFGA_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]  cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_CTR   = 6'b000100,
    S_SCAN  = 6'b001000,
    S_DIV   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [RAD_W-1:0]  radius_r;
  logic [CNT_W-1:0]  minv_r;
  logic [COLC_W-1:0] cols_r;
  logic [ROW_W-1:0]  rows_r;

  logic [COL_W-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [ROW_W-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;

  logic [COL_W-1:0] lo_c_r, lo_c_nxt, hi_c_r, hi_c_nxt, sc_r, sc_nxt;
  logic [ROW_W-1:0] hi_r_r, hi_r_nxt, sr_r, sr_nxt;
  logic             iss_done_r, iss_done_nxt, rd_v_r, rd_v_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PIX_W-1:0] res_r, res_nxt;
  logic             fill_r, fill_nxt;

  logic             ov_r, ov_nxt;
  logic [PIX_W-1:0] od_r, od_nxt;
  logic             ofill_r, ofill_nxt, olast_r, olast_nxt;

  logic [COLC_W-1:0] cols_eff, cols_m1;
  logic [ROW_W-1:0]  rows_eff, rows_m1;
  logic [CNT_W-1:0]  minv_eff;

  logic              acc, clr_pre, wr_en;
  logic [ROW_W-1:0]  ir;
  logic [COL_W-1:0]  ic;
  logic [COLC_W-1:0] ic_inc, oc_inc;
  logic              out_bad, win_ready, last_pix;
  logic [ROW_W:0]    nr_sum;
  logic [COLC_W-1:0] nc_sum;
  logic [ROW_W-1:0]  nr, lo_r;
  logic [COL_W-1:0]  nc, lo_c;
  logic              issue, last_iss, scan_fin, emit_go;
  logic [ADDR_W-1:0] rd_addr;
  logic [PIX_W-1:0]  rd_data;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  // register values held to their legal ranges
  always_comb begin
    if (cols_r == '0) cols_eff = COLC_W'(1);
    else if (cols_r > COLC_W'(MAX_COLS)) cols_eff = COLC_W'(MAX_COLS);
    else cols_eff = cols_r;
    if (rows_r == '0) rows_eff = ROW_W'(1);
    else if (rows_r > ROW_W'(MAX_ROWS)) rows_eff = ROW_W'(MAX_ROWS);
    else rows_eff = rows_r;
    minv_eff = (minv_r == '0) ? CNT_W'(1) : minv_r;
  end
  assign cols_m1 = cols_eff - 1'b1;
  assign rows_m1 = rows_eff - 1'b1;

  assign in_tready = (state_r == S_IDLE);
  assign acc       = in_tvalid && in_tready;

  // input side: stale positions of a finished frame are dropped first
  assign clr_pre = (in_row_r >= rows_eff) &&
                   ((out_row_r >= rows_eff) || ({1'b0, out_col_r} >= cols_eff));
  assign ir      = clr_pre ? '0 : in_row_r;
  assign ic      = clr_pre ? '0 : in_col_r;
  assign wr_en   = acc && !in_tuser && (ir < rows_eff);
  assign ic_inc  = {1'b0, ic} + 1'b1;

  // window bounds of the next pending pixel
  assign out_bad = (out_row_r >= rows_eff) || ({1'b0, out_col_r} >= cols_eff);
  assign nr_sum  = {1'b0, out_row_r} + (ROW_W + 1)'(radius_r);
  assign nc_sum  = {1'b0, out_col_r} + COLC_W'(radius_r);
  assign nr      = (nr_sum > {1'b0, rows_m1}) ? rows_m1 : nr_sum[ROW_W-1:0];
  assign nc      = (nc_sum > cols_m1) ? cols_m1[COL_W-1:0] : nc_sum[COL_W-1:0];
  assign lo_r    = (out_row_r >= ROW_W'(radius_r)) ? out_row_r - ROW_W'(radius_r) : '0;
  assign lo_c    = (out_col_r >= COL_W'(radius_r)) ? out_col_r - COL_W'(radius_r) : '0;
  // last window pixel already arrived: raster order compare, no multiply
  assign win_ready = (in_row_r >= rows_eff) || (nr < in_row_r) ||
                     ((nr == in_row_r) && (nc < in_col_r));
  assign last_pix  = (out_row_r == rows_m1) && ({1'b0, out_col_r} == cols_m1);
  assign oc_inc    = {1'b0, out_col_r} + 1'b1;

  assign issue    = (state_r == S_SCAN) && !iss_done_r;
  assign last_iss = (sr_r == hi_r_r) && (sc_r == hi_c_r);
  assign scan_fin = (state_r == S_SCAN) && iss_done_r && !rd_v_r;
  assign emit_go  = (state_r == S_EMIT) && (!ov_r || out_tready);

  assign rd_addr = (state_r == S_CHECK) ? {out_row_r[LROW_W-1:0], out_col_r}
                                        : {sr_r[LROW_W-1:0], sc_r};

  assign div_req.start    = scan_fin && (cnt_r >= minv_eff);
  assign div_req.dividend = sum_r;
  assign div_req.divisor  = cnt_r;

  always_comb begin
    state_nxt    = state_r;
    in_col_nxt   = in_col_r;
    in_row_nxt   = in_row_r;
    out_col_nxt  = out_col_r;
    out_row_nxt  = out_row_r;
    lo_c_nxt     = lo_c_r;
    hi_c_nxt     = hi_c_r;
    hi_r_nxt     = hi_r_r;
    sc_nxt       = sc_r;
    sr_nxt       = sr_r;
    iss_done_nxt = iss_done_r;
    rd_v_nxt     = issue;
    sum_nxt      = sum_r;
    cnt_nxt      = cnt_r;
    res_nxt      = res_r;
    fill_nxt     = fill_r;
    ov_nxt       = ov_r && !out_tready;
    od_nxt       = od_r;
    ofill_nxt    = ofill_r;
    olast_nxt    = olast_r;

    case (state_r)
      S_IDLE: begin
        if (acc) begin
          out_row_nxt = clr_pre ? '0 : out_row_r;
          out_col_nxt = clr_pre ? '0 : out_col_r;
          in_row_nxt  = ir;
          in_col_nxt  = ic;
          if (wr_en) begin
            if (ic_inc >= cols_eff) begin
              in_col_nxt = '0;
              in_row_nxt = ir + 1'b1;
            end else begin
              in_col_nxt = ic_inc[COL_W-1:0];
            end
          end
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (out_bad) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
          state_nxt   = S_IDLE;
        end else if (win_ready) begin
          lo_c_nxt  = lo_c;
          hi_c_nxt  = nc;
          hi_r_nxt  = nr;
          sc_nxt    = lo_c;
          sr_nxt    = lo_r;
          state_nxt = S_CTR;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_CTR: begin
        res_nxt  = rd_data;
        fill_nxt = 1'b0;
        if (rd_data != '0) begin
          state_nxt = S_EMIT;
        end else begin
          iss_done_nxt = 1'b0;
          sum_nxt      = '0;
          cnt_nxt      = '0;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (issue) begin
          iss_done_nxt = last_iss;
          if (sc_r == hi_c_r) begin
            sc_nxt = lo_c_r;
            sr_nxt = sr_r + 1'b1;
          end else begin
            sc_nxt = sc_r + 1'b1;
          end
        end
        if (rd_v_r && (rd_data != '0)) begin
          sum_nxt = sum_r + SUM_W'(rd_data);
          cnt_nxt = cnt_r + 1'b1;
        end
        if (scan_fin) begin
          state_nxt = div_req.start ? S_DIV : S_EMIT;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          res_nxt   = div_rsp.quotient;
          fill_nxt  = 1'b1;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          ov_nxt    = 1'b1;
          od_nxt    = res_r;
          ofill_nxt = fill_r;
          olast_nxt = last_pix;
          if (last_pix) begin
            in_col_nxt  = '0;
            in_row_nxt  = '0;
            out_col_nxt = '0;
            out_row_nxt = '0;
          end else if (oc_inc >= cols_eff) begin
            out_col_nxt = '0;
            out_row_nxt = out_row_r + 1'b1;
          end else begin
            out_col_nxt = oc_inc[COL_W-1:0];
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      radius_r   <= RADIUS_RST;
      minv_r     <= MINV_RST;
      cols_r     <= COLS_RST;
      rows_r     <= ROWS_RST;
      in_col_r   <= '0;
      in_row_r   <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      iss_done_r <= 1'b0;
      rd_v_r     <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_col_r   <= in_col_nxt;
      in_row_r   <= in_row_nxt;
      out_col_r  <= out_col_nxt;
      out_row_r  <= out_row_nxt;
      iss_done_r <= iss_done_nxt;
      rd_v_r     <= rd_v_nxt;
      ov_r       <= ov_nxt;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_RADIUS: radius_r <= cfg_data[RAD_W-1:0];
          CFG_MINV:   minv_r   <= cfg_data[CNT_W-1:0];
          CFG_COLS:   cols_r   <= cfg_data[COLC_W-1:0];
          CFG_ROWS:   rows_r   <= cfg_data[ROW_W-1:0];
          default:    radius_r <= radius_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    lo_c_r  <= lo_c_nxt;
    hi_c_r  <= hi_c_nxt;
    hi_r_r  <= hi_r_nxt;
    sc_r    <= sc_nxt;
    sr_r    <= sr_nxt;
    sum_r   <= sum_nxt;
    cnt_r   <= cnt_nxt;
    res_r   <= res_nxt;
    fill_r  <= fill_nxt;
    od_r    <= od_nxt;
    ofill_r <= ofill_nxt;
    olast_r <= olast_nxt;
  end

  rihf_line_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr ({ir[LROW_W-1:0], ic}),
    .wr_data (in_tdata),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rihf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ofill_r;
  assign out_tlast  = olast_r;

`ifndef ASSERT_OFF
  // a filled value is a mean of nonzero pixels, so it is never zero
  a_fill_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata != '0)
    else $error("filled item with zero value");

  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == S_DIV)
    else $error("divider finished outside of divide state");

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> cnt_r <= CNT_W'(WIN_MAX))
    else $error("window count above window size");

  a_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHECK |-> in_row_r <= rows_eff)
    else $error("input row beyond frame");
`endif

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import rihf_pkg::*;

  localparam int LIMIT     = 1_000_000;
  localparam int DRAIN_GAP = 200;     // worst item: a filled hole with a full window
  localparam int HOLD_LEN  = 400;

  typedef struct {
    logic [PIX_W-1:0] value;
    logic             filled;
    logic             last;
  } px_result_t;

  class hole_fill_board;
    int unsigned px_store [MAX_ROWS*MAX_COLS];
    logic [RAD_W-1:0]  radius;
    logic [CNT_W-1:0]  min_cnt;
    logic [COLC_W-1:0] cols_reg;
    logic [ROW_W-1:0]  rows_reg;
    int unsigned in_c, in_r, out_c, out_r;
    px_result_t pending_px[$];
    int errors, n_out, n_filled, n_frames;
    bit frame_done;

    function new();
      radius = RADIUS_RST;
      min_cnt = MINV_RST;
      cols_reg = COLS_RST;
      rows_reg = ROWS_RST;
      clear_pos();
    endfunction

    function void clear_pos();
      in_c = 0; in_r = 0; out_c = 0; out_r = 0;
    endfunction

    function int unsigned n_cols();
      if (cols_reg == 0) return 1;
      return (cols_reg > MAX_COLS) ? MAX_COLS : cols_reg;
    endfunction

    function int unsigned n_rows();
      if (rows_reg == 0) return 1;
      return (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
    endfunction

    function void set_reg(cfg_idx_t a, logic [CFG_W-1:0] d);
      case (a)
        CFG_RADIUS: radius = d[RAD_W-1:0];
        CFG_MINV:   min_cnt = d[CNT_W-1:0];
        CFG_COLS:   cols_reg = d[COLC_W-1:0];
        CFG_ROWS:   rows_reg = d[ROW_W-1:0];
        default:    radius = radius;
      endcase
      clear_pos();
    endfunction

    function void note_input(logic [PIX_W-1:0] v, logic fl);
      int unsigned cols, rows, rad, mv, nr, nc, r, c, cnt;
      longint unsigned need, got, sum;
      px_result_t e;
      cols = n_cols();
      rows = n_rows();
      rad = (radius > MAX_RADIUS) ? MAX_RADIUS : radius;
      mv = (min_cnt == 0) ? 1 : min_cnt;
      if (in_r >= rows && (out_r >= rows || out_c >= cols)) clear_pos();
      if (!fl && in_r < rows) begin
        px_store[in_r*MAX_COLS + in_c] = v;
        in_c++;
        if (in_c >= cols) begin
          in_c = 0;
          in_r++;
        end
      end
      if (out_r >= rows || out_c >= cols) begin
        clear_pos();
        return;
      end
      nr = out_r + rad; if (nr > rows - 1) nr = rows - 1;
      nc = out_c + rad; if (nc > cols - 1) nc = cols - 1;
      need = nr; need = need * cols + nc;
      got = in_r; got = got * cols + in_c;
      if (!(in_r >= rows || need < got)) return;
      e.value = px_store[out_r*MAX_COLS + out_c];
      e.filled = 0;
      if (e.value == 0) begin
        sum = 0;
        cnt = 0;
        for (r = (out_r >= rad ? out_r - rad : 0); r <= nr; r++)
          for (c = (out_c >= rad ? out_c - rad : 0); c <= nc; c++)
            if (px_store[r*MAX_COLS + c] != 0) begin
              sum += px_store[r*MAX_COLS + c];
              cnt++;
            end
        if (cnt >= mv) begin
          e.value = PIX_W'(sum / cnt);
          e.filled = 1;
        end
      end
      e.last = (out_r == rows - 1) && (out_c == cols - 1);
      pending_px.push_back(e);
      if (e.last) begin
        clear_pos();
        frame_done = 1;
      end else begin
        out_c++;
        if (out_c >= cols) begin
          out_c = 0;
          out_r++;
        end
      end
    endfunction

    function void check(logic [PIX_W-1:0] d, logic u, logic l);
      px_result_t e;
      if (pending_px.size() == 0) begin
        $display("%0t: unexpected item: expected none, actual %h filled %b last %b",
                 $time, d, u, l);
        errors++;
        return;
      end
      e = pending_px.pop_front();
      n_out++;
      if (u) n_filled++;
      if (l) n_frames++;
      if (d !== e.value) begin
        $display("%0t: range_out expected %h actual %h", $time, e.value, d);
        errors++;
      end
      if (u !== e.filled) begin
        $display("%0t: was_filled expected %b actual %b", $time, e.filled, u);
        errors++;
      end
      if (l !== e.last) begin
        $display("%0t: frame_end expected %b actual %b", $time, e.last, l);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 0;
  logic              rst_n;
  logic              in_tvalid, in_tready, in_tuser;
  logic [PIX_W-1:0]  in_tdata;
  logic              out_tvalid, out_tready, out_tuser, out_tlast;
  logic [PIX_W-1:0]  out_tdata;
  logic              cfg_we;
  logic [CFGA_W-1:0] cfg_addr;
  logic [CFG_W-1:0]  cfg_data;

  hole_fill_board sb = new();
  bit quiet, in_random, held;
  int hold_left, cycles, n_sent;

  range_image_hole_fill_core i_dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) sb.check(out_tdata, out_tuser, out_tlast);

  // receiver: random stalls (none while quiet), one long hold while the sender is offering items
  initial begin
    out_tready = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready <= 0;
        hold_left--;
      end else if (quiet) begin
        out_tready <= 1;
      end else if (in_random && !held && n_sent >= 400 && in_tvalid) begin
        held = 1;
        hold_left = HOLD_LEN;
        out_tready <= 0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= 15);
      end
    end
  end

  function automatic logic [PIX_W-1:0] rand_pix();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 0;
      4:          return 32'hFFFF_FFFF;
      5:          return $urandom_range(1, 3);
      default:    return $urandom;
    endcase
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_item(logic [PIX_W-1:0] v, logic fl);
    if (!quiet)
      while ($urandom_range(0, 99) < 15) begin
        in_tvalid <= 0;
        @(negedge clk);
      end
    in_tvalid <= 1;
    in_tdata <= v;
    in_tuser <= fl;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(v, fl);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic write_cfg(int rad, int mv, int cols, int rows);
    in_tvalid <= 0;
    while (sb.pending_px.size() != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
    cfg_we <= 1;
    cfg_addr <= CFG_RADIUS; cfg_data <= CFG_W'(rad);  sb.set_reg(CFG_RADIUS, CFG_W'(rad));
    @(negedge clk);
    cfg_addr <= CFG_MINV;   cfg_data <= CFG_W'(mv);   sb.set_reg(CFG_MINV, CFG_W'(mv));
    @(negedge clk);
    cfg_addr <= CFG_COLS;   cfg_data <= CFG_W'(cols); sb.set_reg(CFG_COLS, CFG_W'(cols));
    @(negedge clk);
    cfg_addr <= CFG_ROWS;   cfg_data <= CFG_W'(rows); sb.set_reg(CFG_ROWS, CFG_W'(rows));
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // one frame's pixels (fixed ones first), flushes to the last result; noise adds stray items
  task automatic run_frame(bit noise, logic [PIX_W-1:0] fixed[$]);
    int unsigned n;
    sb.frame_done = 0;
    n = sb.n_cols() * sb.n_rows();
    for (int unsigned i = 0; i < n; i++) begin
      if (noise && $urandom_range(0, 99) < 3) send_item($urandom, 1'b1);
      send_item(i < fixed.size() ? fixed[i] : rand_pix(), 1'b0);
    end
    while (!sb.frame_done) begin
      // a pixel while draining gets dropped
      if (noise && $urandom_range(0, 99) < 3) send_item(rand_pix(), 1'b0);
      else send_item($urandom, 1'b1);
    end
    if (noise && $urandom_range(0, 3) == 0) send_item($urandom, 1'b1);
  endtask

  initial begin
    logic [PIX_W-1:0] none[$];
    int frame;
    rst_n = 0;
    in_tvalid = 0; in_tdata = 0; in_tuser = 0;
    cfg_we = 0; cfg_addr = CFG_RADIUS; cfg_data = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // partial frame at reset settings, abandoned by the config write
    send_item(32'h1234_5678, 1'b0);
    send_item(32'h0, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b1);
    send_item(32'h0, 1'b0);

    write_cfg(1, 1, 4, 3);
    run_frame(1'b0, '{0, 32'hFFFF_FFFF, 0, 5, 0, 0, 0, 32'hFFFF_FFFF, 1, 0, 2, 0});
    // zero registers are held at their minimum: 1x1 frame, lone hole stays zero
    write_cfg(3, 0, 0, 0);
    run_frame(1'b0, '{0});
    run_frame(1'b0, '{7});
    // threshold above any window count: holes never filled
    write_cfg(2, 63, 5, 2);
    run_frame(1'b0, '{0, 0, 9, 0, 3, 0, 0, 0, 0, 0});

    in_random = 1;
    frame = 0;
    while (n_sent < 1000) begin
      if (frame == 4) write_cfg(3, 2, 12, 12);
      else if (frame == 9) write_cfg(3, 49, 1, 255);
      else if ($urandom_range(0, 2) != 0 || frame < 2)
        write_cfg($urandom_range(0, 3),
                  $urandom_range(0, 4) == 0 ? $urandom_range(0, 63) : $urandom_range(0, 4),
                  $urandom_range(1, 10), $urandom_range(1, 8));
      quiet = (frame >= 12 && frame < 18);
      run_frame(1'b1, none);
      frame++;
    end
    quiet = 0;
    in_tvalid <= 0;

    while (sb.pending_px.size() != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
    $display("Sent %0d items over %0d random frames plus directed frames;", n_sent, frame);
    $display("checked %0d pixels, %0d filled, %0d frame ends.",
             sb.n_out, sb.n_filled, sb.n_frames);
    if (sb.errors == 0 && sb.pending_px.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/rihf_pkg.sv
hdl/rihf_line_mem.sv
hdl/rihf_div.sv
hdl/range_image_hole_fill_core.sv
bench/tb.sv
